// ===== hdl/fatmt_pkg.sv =====
package fatmt_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned TURN = 5760;
  localparam int unsigned QUARTER = 1440;
  localparam int unsigned ANG_W = 13;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned NSTG = 6;
  localparam logic [30:0] RAD_K = 31'd1199381129;

  typedef logic signed [33:0] q30_t;
  typedef logic [31:0] uq30_t;

  typedef enum logic [1:0] {
    Q_0 = 2'd0,
    Q_1 = 2'd1,
    Q_2 = 2'd2,
    Q_3 = 2'd3
  } quad_t;

  function automatic logic [7:0] sdiv_f(input int unsigned i);
    case (i)
      0: sdiv_f = 8'd156;
      1: sdiv_f = 8'd110;
      2: sdiv_f = 8'd72;
      3: sdiv_f = 8'd42;
      4: sdiv_f = 8'd20;
      default: sdiv_f = 8'd6;
    endcase
  endfunction

  function automatic logic [7:0] cdiv_f(input int unsigned i);
    case (i)
      0: cdiv_f = 8'd182;
      1: cdiv_f = 8'd132;
      2: cdiv_f = 8'd90;
      3: cdiv_f = 8'd56;
      4: cdiv_f = 8'd30;
      default: cdiv_f = 8'd12;
    endcase
  endfunction

  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    logic [67:0] m;
    p = 68'(a) * 68'(b);
    m = p[67] ? 68'(-p) : 68'(p);
    m = (m + (68'd1 << 29)) >> 30;
    mul30 = p[67] ? -q30_t'(m) : q30_t'(m);
  endfunction

  // angle mod TURN, angle < 2*TURN assumed by callers
  function automatic logic [12:0] wrap_f(input logic [13:0] a);
    wrap_f = (a >= 14'(TURN)) ? 13'(a - 14'(TURN)) : a[12:0];
  endfunction

endpackage

// ===== hdl/fatmt_cell.sv =====
module fatmt_cell import fatmt_pkg::*; #(
  parameter int unsigned SDIV = 156,
  parameter int unsigned CDIV = 182
) (
  input  logic  clk,
  input  uq30_t x2_i,
  input  uq30_t ts_i,
  input  uq30_t tc_i,
  output uq30_t ts_o,
  output uq30_t tc_o
);
  // floor(n / d) for 32-bit n as (n * ceil(2^(32+l) / d)) >> (32+l), l = clog2(d)
  localparam int unsigned SSH = 32 + $clog2(SDIV);
  localparam int unsigned CSH = 32 + $clog2(CDIV);
  localparam logic [32:0] SREC = 33'(((64'd1 << SSH) + 64'(SDIV) - 64'd1) / 64'(SDIV));
  localparam logic [32:0] CREC = 33'(((64'd1 << CSH) + 64'(CDIV) - 64'd1) / 64'(CDIV));

  uq30_t ys_r, yc_r;
  uq30_t ys_nxt, yc_nxt;
  uq30_t ts_r, tc_r;
  logic [63:0] ps, pc;
  logic [64:0] qs, qc;
  uq30_t ts_nxt, tc_nxt;

  always_comb begin
    ps = 64'(x2_i) * 64'(ts_i);
    pc = 64'(x2_i) * 64'(tc_i);
    ys_nxt = 32'(ps >> 30);
    yc_nxt = 32'(pc >> 30);
    qs = 65'(ys_r) * 65'(SREC);
    qc = 65'(yc_r) * 65'(CREC);
    ts_nxt = 32'(32'd1 << 30) - 32'(qs >> SSH);
    tc_nxt = 32'(32'd1 << 30) - 32'(qc >> CSH);
  end

  always_ff @(posedge clk) begin
    ys_r <= ys_nxt;
    yc_r <= yc_nxt;
    ts_r <= ts_nxt;
    tc_r <= tc_nxt;
  end

  assign ts_o = ts_r;
  assign tc_o = tc_r;
endmodule

// ===== hdl/fatmt_sincos.sv =====
module fatmt_sincos import fatmt_pkg::*; (
  input  logic        clk,
  input  logic [12:0] ang_i,
  output q30_t        sin_o,
  output q30_t        cos_o
);
  logic [10:0] r;
  quad_t q;
  uq30_t x_r, x2_r;
  quad_t q_r;
  logic [41:0] xp;
  logic [63:0] x2p;
  uq30_t ts [NSTG+1];
  uq30_t tc [NSTG+1];
  uq30_t xd [NSTG+1];
  uq30_t x2d [NSTG+1];
  quad_t qd [NSTG+1];
  uq30_t xh_r [NSTG];
  uq30_t x2h_r [NSTG];
  quad_t qh_r [NSTG];
  logic [63:0] sp, cp;
  q30_t s0_r, c0_r;
  quad_t qo_r;
  q30_t sin_r, cos_r;
  q30_t cv;

  always_comb begin
    if (ang_i >= 13'(3*QUARTER)) begin
      q = Q_3; r = 11'(ang_i - 13'(3*QUARTER));
    end else if (ang_i >= 13'(2*QUARTER)) begin
      q = Q_2; r = 11'(ang_i - 13'(2*QUARTER));
    end else if (ang_i >= 13'(QUARTER)) begin
      q = Q_1; r = 11'(ang_i - 13'(QUARTER));
    end else begin
      q = Q_0; r = ang_i[10:0];
    end
    xp = 42'(r) * 42'(RAD_K);
  end

  always_ff @(posedge clk) begin
    x_r <= 32'((xp + 42'd512) >> 10);
    q_r <= q;
  end

  always_comb x2p = 64'(x_r) * 64'(x_r);

  always_ff @(posedge clk) begin
    x2_r <= 32'((x2p + 64'd536870912) >> 30);
    xd[0] <= x_r;
    qd[0] <= q_r;
  end

  assign ts[0] = 32'd1 << 30;
  assign tc[0] = 32'd1 << 30;
  assign x2d[0] = x2_r;

  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    fatmt_cell #(.SDIV(int'(sdiv_f(i))), .CDIV(int'(cdiv_f(i)))) u_cell (
      .clk(clk), .x2_i(x2d[i]), .ts_i(ts[i]), .tc_i(tc[i]),
      .ts_o(ts[i+1]), .tc_o(tc[i+1])
    );
    always_ff @(posedge clk) begin
      xh_r[i] <= xd[i];
      x2h_r[i] <= x2d[i];
      qh_r[i] <= qd[i];
      xd[i+1] <= xh_r[i];
      x2d[i+1] <= x2h_r[i];
      qd[i+1] <= qh_r[i];
    end
  end

  always_comb begin
    sp = 64'(xd[NSTG]) * 64'(ts[NSTG]);
    cp = 64'(x2d[NSTG]) * 64'(tc[NSTG]);
    cv = q30_t'(34'sd1 << 30) - q30_t'((cp >> 30) >> 1);
  end

  always_ff @(posedge clk) begin
    s0_r <= q30_t'(sp >> 30);
    c0_r <= cv[33] ? '0 : cv;
    qo_r <= qd[NSTG];
  end

  always_ff @(posedge clk) begin
    case (qo_r)
      Q_0: begin sin_r <= s0_r;  cos_r <= c0_r;  end
      Q_1: begin sin_r <= c0_r;  cos_r <= -s0_r; end
      Q_2: begin sin_r <= -s0_r; cos_r <= -c0_r; end
      default: begin sin_r <= -c0_r; cos_r <= s0_r; end
    endcase
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

// ===== hdl/fault_angles_to_moment_tensor_unit.sv =====
// Unit double-couple moment tensor from strike, dip and rake (1/16 degree).
// Fully pipelined: one transaction accepted every cycle, busy is always low.
// out_valid is a delayed copy of start that lines up with the result, which passes
// through six cells per angle plus the trig and product stages. Results cannot be
// stalled.
module fault_angles_to_moment_tensor_unit import fatmt_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ANG_W-1:0]         in_strike_angle,
  input  logic [10:0]              in_dip_angle,
  input  logic signed [ANG_W-1:0]  in_rake_angle,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_m_xx,
  output logic signed [OUT_W-1:0]  out_m_yy,
  output logic signed [OUT_W-1:0]  out_m_zz,
  output logic signed [OUT_W-1:0]  out_m_xy,
  output logic signed [OUT_W-1:0]  out_m_xz,
  output logic signed [OUT_W-1:0]  out_m_yz
);
  localparam int unsigned LAT = 21;

  logic [12:0] a_r [5];
  logic [12:0] st, dp, rk;
  logic signed [14:0] rs;
  q30_t sn [5];
  q30_t cs [5];
  logic [LAT-1:0] vld_r;

  always_comb begin
    st = wrap_f(14'(in_strike_angle));
    dp = 13'(in_dip_angle);
    rs = 15'(in_rake_angle) + 15'(TURN);
    rk = (rs >= 15'(TURN)) ? 13'(rs - 15'(TURN)) : 13'(rs);
  end

  always_ff @(posedge clk) begin
    a_r[0] <= st;
    a_r[1] <= wrap_f({st, 1'b0});
    a_r[2] <= dp;
    a_r[3] <= wrap_f({dp, 1'b0});
    a_r[4] <= rk;
  end

  for (genvar k = 0; k < 5; k++) begin : g_sc
    fatmt_sincos u_sc (.clk(clk), .ang_i(a_r[k]), .sin_o(sn[k]), .cos_o(cs[k]));
  end

  // stage A
  q30_t a1_r, b1_r, a2_r, b2_r, sss_r, css_r, s2s_r, c2s_r, ss_r, csx_r;
  always_ff @(posedge clk) begin
    a1_r <= mul30(sn[2], cs[4]);
    b1_r <= mul30(sn[3], sn[4]);
    a2_r <= mul30(cs[2], cs[4]);
    b2_r <= mul30(cs[3], sn[4]);
    sss_r <= mul30(sn[0], sn[0]);
    css_r <= mul30(cs[0], cs[0]);
    s2s_r <= sn[1];
    c2s_r <= cs[1];
    ss_r <= sn[0];
    csx_r <= cs[0];
  end

  // stage B
  q30_t p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r, p8_r, p9_r, p10_r;
  always_ff @(posedge clk) begin
    p1_r <= mul30(a1_r, s2s_r);
    p2_r <= mul30(b1_r, sss_r);
    p3_r <= mul30(b1_r, css_r);
    p4_r <= mul30(a1_r, c2s_r);
    p5_r <= mul30(b1_r, s2s_r);
    p6_r <= mul30(a2_r, csx_r);
    p7_r <= mul30(b2_r, ss_r);
    p8_r <= mul30(a2_r, ss_r);
    p9_r <= mul30(b2_r, csx_r);
    p10_r <= '0;
  end

  // stage C
  q30_t m11_r, m22_r, m12_r, m13_r, m23_r;
  always_ff @(posedge clk) begin
    m11_r <= -(p1_r + p2_r);
    m22_r <= p1_r - p3_r;
    m12_r <= p4_r + mul30(p5_r, q30_t'(34'sd1 << 29)) + p10_r;
    m13_r <= -(p6_r + p7_r);
    m23_r <= -(p8_r - p9_r);
  end

  function automatic logic [OUT_W-1:0] to_out(input q30_t v);
    localparam int unsigned SH = 30 - OUT_FRAC_BITS;
    logic [34:0] m;
    logic [34:0] lim;
    logic [34:0] rr;
    m = v[33] ? 35'(-v) : 35'(v);
    lim = 35'd1 << OUT_FRAC_BITS;
    if (SH > 0) m = (m + (35'd1 << (SH - 1))) >> SH;
    if (m > lim) m = lim;
    rr = v[33] ? -m : m;
    to_out = rr[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    out_m_xx <= to_out(m11_r);
    out_m_yy <= to_out(m22_r);
    out_m_zz <= to_out(-(m11_r + m22_r));
    out_m_xy <= to_out(m12_r);
    out_m_xz <= to_out(m13_r);
    out_m_yz <= to_out(m23_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign busy = 1'b0;
endmodule

// ===== hdl/fatmt_checker.sv =====
module fatmt_checker import fatmt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic signed [OUT_W-1:0] out_m_xx,
  input logic signed [OUT_W-1:0] out_m_yy,
  input logic signed [OUT_W-1:0] out_m_zz
);
  a_nobusy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##21 out_valid) else $error("result missing");
  a_noinv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 21)) else $error("spurious result");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_m_xx, out_m_yy, out_m_zz}))
    else $error("unknown result");
endmodule

bind fault_angles_to_moment_tensor_unit fatmt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_m_xx(out_m_xx), .out_m_yy(out_m_yy), .out_m_zz(out_m_zz)
);
